[sv/iat_pkg.sv]
// shared types, token codes and character class helpers for the tokenizer
// no dependencies
package iat_pkg;

    localparam int OFFSET_BITS = 20;
    localparam int LEN_BITS    = OFFSET_BITS + 1;
    localparam int INDENT_BITS = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam logic [62:0] INT_MAX63 = {63{1'b1}};
    localparam logic [INDENT_BITS-1:0] INDENT_MAX = {INDENT_BITS{1'b1}};
    localparam logic [3:0] TAB_RESET = 4'd4;

    typedef enum logic [3:0] {
        K_EOF    = 4'd0,
        K_NLSEMI = 4'd1,
        K_UNDER  = 4'd2,
        K_BSLASH = 4'd3,
        K_COMMA  = 4'd4,
        K_LPAREN = 4'd5,
        K_SEMI   = 4'd6,
        K_RPAREN = 4'd7,
        K_ARROW  = 4'd8,
        K_SYMBOL = 4'd9,
        K_INT    = 4'd10,
        K_COLON  = 4'd11,
        K_EQUALS = 4'd12,
        K_ERROR  = 4'd13
    } t_kind;

    typedef enum logic [1:0] {
        M_IDLE  = 2'd0,
        M_SYM   = 2'd1,
        M_INT   = 2'd2,
        M_MINUS = 2'd3
    } t_mode;

    typedef struct packed {
        t_kind                 kind;
        logic [62:0]           ival;
        logic                  ovf;
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]   len;
        logic [7:0]            ech;
    } t_tok;

    // up to three tokens caused by one input word
    typedef struct packed {
        logic [1:0] cnt;
        t_tok [2:0] tok;
    } t_rec;

    typedef struct packed {
        t_mode                  mode;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] tstart;
        logic [62:0]            acc;
        logic                   aovf;
        logic [INDENT_BITS-1:0] base;
        logic [INDENT_BITS-1:0] ind;
        logic                   sawnl;
        logic [OFFSET_BITS-1:0] nloff;
        logic                   awf;
    } t_lex;

    typedef struct packed {
        t_lex s;
        t_rec r;
    } t_work;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            8'h5F:   k = K_UNDER;
            8'h5C:   k = K_BSLASH;
            8'h2C:   k = K_COMMA;
            8'h28:   k = K_LPAREN;
            8'h3B:   k = K_SEMI;
            8'h29:   k = K_RPAREN;
            8'h3A:   k = K_COLON;
            8'h3D:   k = K_EQUALS;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic t_lex lex_init();
        t_lex s;
        s = '0;
        s.mode = M_IDLE;
        s.awf  = 1'b1;
        return s;
    endfunction

endpackage

[sv/indent_aware_tokenizer.sv]
// top level of the indentation-aware tokenizer
// depends on iat_pkg, iat_front, iat_queue, iat_back
//
// channel   dir  fields
// s_axis    in   tdata[7:0] char_byte, tuser has_byte, tlast end_of_file
// m_axis    out  tdata int_value..error_char, tuser token_kind, tlast last_of_run
// cfg       in   i_cfg_data tab_width
//
// one input word per cycle; the front end lexes each byte combinationally
// and writes up to three tokens as one record into a four-entry queue. the back
// end sends one token per cycle unless stalled, so bursts of multi-token words
// fill the queue and then s_axis_tready drops until the back end frees a slot.
// synchronous active-low reset returns to the start-of-file state, tab width 4.
module indent_aware_tokenizer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // char_byte[7:0]
    input  logic         s_axis_tuser,   // has_byte
    input  logic         s_axis_tlast,   // end_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // int_value[62:0], int_overflow[63], start_offset[83:64],
    // token_length[104:84], error_char[112:105], zero pad
    output logic [119:0] m_axis_tdata,
    output logic [3:0]   m_axis_tuser,   // token_kind
    output logic         m_axis_tlast,   // last_of_run
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_data
);
    import iat_pkg::*;

    logic take, push, full, qvalid, pop;
    t_rec rec, head;
    t_tok tok;

    assign s_axis_tready = !full;
    assign take          = s_axis_tvalid && !full;
    assign o_cfg_ready   = 1'b1;

    iat_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_char     (s_axis_tdata),
        .i_has_byte (s_axis_tuser),
        .i_eof      (s_axis_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_rec      (rec)
    );

    iat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (qvalid),
        .o_head  (head)
    );

    iat_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (qvalid),
        .i_head  (head),
        .o_pop   (pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_tok   (tok),
        .o_last  (m_axis_tlast)
    );

    // pack the result word
    assign m_axis_tuser = tok.kind;
    assign m_axis_tdata = {7'd0, tok.ech, tok.len, tok.start, tok.ovf, tok.ival};

endmodule

[sv/iat_front.sv]
// front end: lexer state, classifies each byte and builds its token record
// depends on iat_pkg
module iat_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_char,
    input  logic        i_has_byte,
    input  logic        i_eof,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    output logic        o_push,
    output iat_pkg::t_rec o_rec
);
    import iat_pkg::*;

    t_lex       r_lex, n_lex;
    logic [3:0] r_tab;

    function automatic t_work put(input t_work w, input t_kind k, input logic [62:0] iv,
                                  input logic ov, input logic [OFFSET_BITS-1:0] st,
                                  input logic [LEN_BITS-1:0] ln, input logic [7:0] ec);
        t_work o;
        o = w;
        if (w.r.cnt != 2'd3) begin
            o.r.tok[w.r.cnt] = '{kind: k, ival: iv, ovf: ov, start: st, len: ln, ech: ec};
            o.r.cnt = w.r.cnt + 2'd1;
        end
        return o;
    endfunction

    function automatic t_work error_at(input t_work w, input logic [OFFSET_BITS-1:0] off,
                                       input logic [7:0] c);
        t_work o;
        o = w;
        if (o.s.awf) o.s.base = '0;
        o = put(o, K_ERROR, '0, 1'b0, off, LEN_BITS'(1), c);
        o.s.ind   = '0;
        o.s.sawnl = 1'b0;
        return o;
    endfunction

    function automatic t_work commit_first(input t_work w);
        t_work o;
        o = w;
        if (o.s.awf) begin
            o.s.base = o.s.ind;
            o.s.awf  = 1'b0;
        end
        o.s.ind   = '0;
        o.s.sawnl = 1'b0;
        return o;
    endfunction

    function automatic t_work finish(input t_work w, input logic [OFFSET_BITS-1:0] e);
        t_work o;
        logic [OFFSET_BITS-1:0] ln;
        o  = w;
        ln = e - o.s.tstart;
        unique case (o.s.mode)
            M_SYM:   o = put(o, K_SYMBOL, '0, 1'b0, o.s.tstart, LEN_BITS'(ln), '0);
            M_INT:   o = put(o, K_INT, o.s.acc, o.s.aovf, o.s.tstart, LEN_BITS'(ln), '0);
            M_MINUS: o = error_at(o, o.s.tstart, 8'h2D);
            default: ;
        endcase
        o.s.mode  = M_IDLE;
        o.s.ind   = '0;
        o.s.sawnl = 1'b0;
        return o;
    endfunction

    function automatic logic [INDENT_BITS-1:0] add_ind(input logic [INDENT_BITS-1:0] a,
                                                      input logic [3:0] n);
        logic [INDENT_BITS:0] s;
        s = {1'b0, a} + (INDENT_BITS+1)'(n);
        return s[INDENT_BITS] ? INDENT_MAX : s[INDENT_BITS-1:0];
    endfunction

    // per-byte lexing, follows the token rules step by step
    always_comb begin
        t_work w;
        logic  done;
        logic [OFFSET_BITS-1:0] p;
        logic [66:0] prod;
        t_kind pk;
        w.s  = r_lex;
        w.r  = '0;
        done = 1'b0;
        p    = r_lex.pos;
        prod = '0;
        pk   = punct_kind(i_char);
        if (i_has_byte) begin
            unique case (w.s.mode)
                M_SYM: begin
                    if (is_letter(i_char) || is_digit(i_char) || i_char == 8'h5F) done = 1'b1;
                    else w = finish(w, p);
                end
                M_INT: begin
                    if (is_digit(i_char)) begin
                        prod = ({4'b0, w.s.acc} << 3) + ({4'b0, w.s.acc} << 1)
                             + 67'(i_char - 8'h30);
                        if (w.s.aovf || prod > {4'b0, INT_MAX63}) begin
                            w.s.acc  = INT_MAX63;
                            w.s.aovf = 1'b1;
                        end else begin
                            w.s.acc = prod[62:0];
                        end
                        done = 1'b1;
                    end else begin
                        w = finish(w, p);
                    end
                end
                M_MINUS: begin
                    if (i_char == 8'h3E) begin
                        w = commit_first(w);
                        w = put(w, K_ARROW, '0, 1'b0, w.s.tstart, LEN_BITS'(2), '0);
                        w.s.mode = M_IDLE;
                        done = 1'b1;
                    end else begin
                        w = finish(w, p);
                    end
                end
                default: ;
            endcase
            if (!done) begin
                if (i_char == 8'h20 || (i_char >= 8'h09 && i_char <= 8'h0D)) begin
                    if (i_char == 8'h0A) begin
                        w.s.sawnl = 1'b1;
                        w.s.nloff = p;
                        w.s.ind   = '0;
                    end else if (i_char == 8'h20) begin
                        w.s.ind = add_ind(w.s.ind, 4'd1);
                    end else begin
                        w.s.ind = add_ind(w.s.ind, r_tab);
                    end
                end else begin
                    if (w.s.sawnl && !w.s.awf && w.s.ind == w.s.base)
                        w = put(w, K_NLSEMI, '0, 1'b0, w.s.nloff, LEN_BITS'(1), '0);
                    w.s.sawnl = 1'b0;
                    if (pk != K_EOF) begin
                        w = commit_first(w);
                        w = put(w, pk, '0, 1'b0, p, LEN_BITS'(1), '0);
                    end else if (is_letter(i_char)) begin
                        w = commit_first(w);
                        w.s.mode   = M_SYM;
                        w.s.tstart = p;
                    end else if (is_digit(i_char)) begin
                        w = commit_first(w);
                        w.s.mode   = M_INT;
                        w.s.tstart = p;
                        w.s.acc    = 63'(i_char - 8'h30);
                        w.s.aovf   = 1'b0;
                    end else if (i_char == 8'h2D) begin
                        w.s.mode   = M_MINUS;
                        w.s.tstart = p;
                    end else begin
                        w = error_at(w, p, i_char);
                    end
                end
            end
            w.s.pos = p + OFFSET_BITS'(1);
        end
        if (i_eof) begin
            w = finish(w, w.s.pos);
            w = put(w, K_EOF, '0, 1'b0, w.s.pos, '0, '0);
            w.s = lex_init();
        end
        n_lex  = w.s;
        o_rec  = w.r;
        o_push = i_take && (w.r.cnt != 2'd0);
    end

    // lexer state and tab width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex <= lex_init();
            r_tab <= TAB_RESET;
        end else begin
            if (i_take) r_lex <= n_lex;
            if (i_cfg_we) r_tab <= i_cfg_data;
        end
    end

endmodule

[sv/iat_queue.sv]
// short queue of token records between the front and back ends
// depends on iat_pkg
module iat_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  iat_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output iat_pkg::t_rec o_head
);
    import iat_pkg::*;

    t_rec                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QPTR_BITS:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_BITS'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_BITS'(1);
            r_cnt <= r_cnt + (QPTR_BITS+1)'(i_push) - (QPTR_BITS+1)'(i_pop);
        end
    end

endmodule

[sv/iat_back.sv]
// back end: walks each record one token at a time into the output register
// depends on iat_pkg
module iat_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  iat_pkg::t_rec i_head,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output iat_pkg::t_tok o_tok,
    output logic          o_last
);
    import iat_pkg::*;

    logic [1:0] r_sub, n_sub;
    logic       r_valid;
    t_tok       r_tok;
    logic       r_last;
    logic       take, last;

    // pick the next token of the head record
    always_comb begin
        take  = i_valid && (!r_valid || i_ready);
        last  = (r_sub == i_head.cnt - 2'd1);
        o_pop = take && last;
        n_sub = r_sub;
        if (take) n_sub = last ? 2'd0 : r_sub + 2'd1;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_sub <= n_sub;
            if (take) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
        if (take) begin
            r_tok  <= i_head.tok[r_sub];
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

endmodule
